/* hw/rtl/bfe_pkg.sv */
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the bit field expander.
// ----------------------------------------------------------------------------
package bfe_pkg;

  localparam int unsigned AccWidthDef  = 64;
  localparam int unsigned ElemBitsW    = 6;
  localparam int unsigned PadW         = 3;
  localparam int unsigned HeldW        = 6;
  localparam int unsigned CntW         = 4;
  localparam int unsigned CfgDataW     = 6;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned MinElemBits  = 8;

  localparam logic [ElemBitsW-1:0] ElemBitsReset = 6'd21;
  localparam logic [PadW-1:0]      PadReset      = 3'd1;

  typedef enum logic [0:0] {
    CfgElementBits = 1'b0,
    CfgPadBytes    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PadW-1:0] pad;
    logic [CntW-1:0] nbytes;
  } job_ctrl_t;

endpackage

/* hw/rtl/bfe_if.sv */
// ----------------------------------------------------------------------------
// bfe_in_if / bfe_out_if
// Valid/ready channels for input and output words.
// ----------------------------------------------------------------------------
interface bfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface bfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       element_end;

  modport source (output valid, output out_byte, output element_end, input ready);
  modport sink   (input valid, input out_byte, input element_end, output ready);
endinterface

/* hw/rtl/bfe_front.sv */
// ----------------------------------------------------------------------------
// bfe_front
// Configuration registers, bit accumulator and element extraction.
// ----------------------------------------------------------------------------
module bfe_front #(
  parameter int unsigned AccWidth = bfe_pkg::AccWidthDef,
  parameter int unsigned ElemW    = 8 * (AccWidth / 8)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  bfe_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [bfe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          final_byte_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output bfe_pkg::job_ctrl_t            job_ctrl_o,
  output logic [ElemW-1:0]              job_elem_o
);
  import bfe_pkg::*;

  localparam logic [ElemBitsW-1:0] MaxBits = ElemBitsW'(AccWidth - 7);
  localparam logic [ElemBitsW-1:0] MinBits = ElemBitsW'(MinElemBits);

  logic [ElemBitsW-1:0] elem_bits_q;
  logic [PadW-1:0]      pad_q;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic [HeldW-1:0]     held_q, held_d;

  logic [ElemBitsW-1:0] eff_bits;
  logic [AccWidth-1:0]  acc_shift;
  logic [AccWidth-1:0]  elem_mask;
  logic [AccWidth-1:0]  elem_full;
  logic [HeldW:0]       held_sum;
  logic [HeldW:0]       held_rem;
  logic [ElemBitsW:0]   nb_sum;
  logic                 take;
  logic                 fire;

  always_comb begin
    if (elem_bits_q < MinBits) begin
      eff_bits = MinBits;
    end else if (elem_bits_q > MaxBits) begin
      eff_bits = MaxBits;
    end else begin
      eff_bits = elem_bits_q;
    end
  end

  assign acc_shift = {acc_q[AccWidth-9:0], in_byte_i};
  assign held_sum  = {1'b0, held_q} + (HeldW+1)'(8);
  assign take      = held_sum >= (HeldW+1)'(eff_bits);
  assign held_rem  = held_sum - (HeldW+1)'(eff_bits);
  assign elem_mask = ~({AccWidth{1'b1}} << eff_bits);
  assign elem_full = (acc_shift >> held_rem[HeldW-1:0]) & elem_mask;
  assign nb_sum    = {1'b0, eff_bits} + (ElemBitsW+1)'(7);

  assign in_ready_o         = !q_full_i;
  assign fire               = in_valid_i && in_ready_o;
  assign push_o             = fire && take;
  assign job_elem_o         = elem_full[ElemW-1:0];
  assign job_ctrl_o.pad     = pad_q;
  assign job_ctrl_o.nbytes  = CntW'(nb_sum[ElemBitsW:3]);

  always_comb begin
    acc_d  = acc_q;
    held_d = held_q;
    if (fire) begin
      if (final_byte_i) begin
        acc_d  = '0;
        held_d = '0;
      end else begin
        acc_d  = acc_shift;
        held_d = take ? held_rem[HeldW-1:0] : held_sum[HeldW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bits_q <= ElemBitsReset;
      pad_q       <= PadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgElementBits: elem_bits_q <= cfg_data_i[ElemBitsW-1:0];
        CfgPadBytes:    pad_q       <= cfg_data_i[PadW-1:0];
      endcase
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(AccWidth - 8))
    else $error("bfe_front: pending bit count out of range");
`endif

endmodule

/* hw/rtl/bfe_queue.sv */
// ----------------------------------------------------------------------------
// bfe_queue
// Short FIFO of extracted elements between front and back.
// ----------------------------------------------------------------------------
module bfe_queue #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] rdata_o
);
  import bfe_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  logic [DataW-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] count_q;

  assign full_o  = count_q == CntQW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntQW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntQW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntQW'(QueueDepth))
    else $error("bfe_queue: count overflow");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bfe_queue: push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("bfe_queue: pop while empty");
`endif

endmodule

/* hw/rtl/bfe_back.sv */
// ----------------------------------------------------------------------------
// bfe_back
// Serializes one queued element per run: pad zeros, then big-endian bytes.
// ----------------------------------------------------------------------------
module bfe_back #(
  parameter int unsigned ElemW = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  bfe_pkg::job_ctrl_t job_ctrl_i,
  input  logic [ElemW-1:0]   job_elem_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               element_end_o
);
  import bfe_pkg::*;

  localparam int unsigned NumBytes = ElemW / 8;
  localparam int unsigned KW = (NumBytes > 1) ? $clog2(NumBytes) : 1;

  logic [CntW-1:0] pos_q, pos_d;
  logic            ovalid_q;
  logic [7:0]      obyte_q;
  logic            oend_q;

  logic [CntW-1:0] total;
  logic [CntW-1:0] last_pos;
  logic [CntW-1:0] k;
  logic            is_pad;
  logic            last;
  logic            out_free;
  logic            step;
  logic [7:0]      sel_byte;

  assign total    = CntW'(job_ctrl_i.pad) + job_ctrl_i.nbytes;
  assign last_pos = total - CntW'(1);
  assign k        = last_pos - pos_q;
  assign is_pad   = pos_q < CntW'(job_ctrl_i.pad);
  assign last     = pos_q == last_pos;
  assign sel_byte = is_pad ? 8'h00 : job_elem_i[{k[KW-1:0], 3'b000} +: 8];

  assign out_free = !ovalid_q || out_ready_i;
  assign step     = q_valid_i && out_free;
  assign pop_o    = step && last;

  assign pos_d = step ? (last ? '0 : pos_q + CntW'(1)) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (step) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      obyte_q <= sel_byte;
      oend_q  <= last;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_byte_o    = obyte_q;
  assign element_end_o = oend_q;

`ifndef SYNTHESIS
  a_pos_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> pos_q <= last_pos)
    else $error("bfe_back: byte position beyond run");
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid_i |-> pos_q == '0)
    else $error("bfe_back: position left over without element");
`endif

endmodule

/* hw/rtl/bit_field_expander.sv */
// ----------------------------------------------------------------------------
// bit_field_expander
// Cuts a big-endian byte stream into element_bits-wide elements and emits
// each as pad_bytes zero words followed by ceil(element_bits/8) data words.
// ----------------------------------------------------------------------------
// An input word is taken every cycle as long as the two-entry element queue
// has room; the front extracts at most one element per input word in the
// same cycle. The back end sends one output word per cycle while the output
// is ready, so an element occupies the output for a run of pad_bytes +
// ceil(element_bits/8) words, and that run length against element_bits/8
// input words per element sets the sustained input rate. The first output
// word of an element goes through its queue entry and then the output
// register. No clearing pass is needed after reset.
module bit_field_expander #(
  parameter int unsigned ACC_WIDTH = bfe_pkg::AccWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  bfe_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [bfe_pkg::CfgDataW-1:0] cfg_data_i,
  bfe_in_if.sink                       in_i,
  bfe_out_if.source                    out_o
);
  import bfe_pkg::*;

  localparam int unsigned ElemW = 8 * (ACC_WIDTH / 8);
  localparam int unsigned CtrlW = $bits(job_ctrl_t);
  localparam int unsigned QW    = ElemW + CtrlW;

  logic             q_full, push, pop, q_valid;
  job_ctrl_t        fr_ctrl, bk_ctrl;
  logic [ElemW-1:0] fr_elem, bk_elem;
  logic [QW-1:0]    q_wdata, q_rdata;

  bfe_front #(
    .AccWidth (ACC_WIDTH),
    .ElemW    (ElemW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_byte_i    (in_i.in_byte),
    .final_byte_i (in_i.final_byte),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_ctrl_o   (fr_ctrl),
    .job_elem_o   (fr_elem)
  );

  assign q_wdata = {fr_ctrl, fr_elem};

  bfe_queue #(
    .DataW (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign bk_ctrl = q_rdata[QW-1:ElemW];
  assign bk_elem = q_rdata[ElemW-1:0];

  bfe_back #(
    .ElemW (ElemW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .job_ctrl_i    (bk_ctrl),
    .job_elem_i    (bk_elem),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .element_end_o (out_o.element_end)
  );

endmodule
